>>> rtl/interpolated_emission_sampler_macros.svh
// assertion helpers used by the sampler module
`ifndef INTERPOLATED_EMISSION_SAMPLER_MACROS_SVH
`define INTERPOLATED_EMISSION_SAMPLER_MACROS_SVH

// condition implies consequence in the same cycle
`define IES_ASSERT_SAME(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) else $error(msg);

// condition implies consequence in the cycle after
`define IES_ASSERT_NEXT(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/iesamp_pkg.sv
package iesamp_pkg;

  localparam logic [1:0] KIND_EXC    = 2'd0;
  localparam logic [1:0] KIND_EMI    = 2'd1;
  localparam logic [1:0] KIND_INT    = 2'd2;
  localparam logic [1:0] KIND_SAMPLE = 2'd3;

  localparam logic [1:0] STAT_SAMPLED = 2'd0;
  localparam logic [1:0] STAT_PASS    = 2'd1;
  localparam logic [1:0] STAT_NONE    = 2'd2;
  localparam logic [1:0] STAT_LOAD    = 2'd3;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_BINS = 2'd1;

  // 1239.84187 * 2^20 and 1240 * 2^20
  localparam logic [31:0] LAMBDA_NUM = 32'd1300068429;
  localparam logic [31:0] EMIT_NUM   = 32'd1300234240;
  localparam logic [19:0] ENERGY_MAX = 20'hFFFFF;

  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  row_index;
    logic [7:0]  bin_index;
    logic [15:0] load_value;
    logic [19:0] excitation_energy;
    logic [15:0] uniform_draw;
  } item_t;

  typedef struct packed {
    logic [19:0] emitted_energy;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic        go;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAM,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_BIN_RD,
    ST_BIN_MUL,
    ST_BIN_SUM,
    ST_BIN_DIV,
    ST_BIN_ACC,
    ST_THRESH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EM_RD,
    ST_EM_CHK,
    ST_EM_DIV
  } state_t;

endpackage

>>> rtl/iesamp_div.sv
module iesamp_div (
  input  logic                 clk,
  input  logic                 rst,
  input  iesamp_pkg::div_req_t req,
  output logic                 busy,
  output logic                 done,
  output logic [31:0]          quo
);
  import iesamp_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [31:0]      rem;
  logic [31:0]      den;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      shifted;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem, quo[31]};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
        cnt  <= '0;
      end else if (busy) begin
        rem <= ge ? 32'(shifted - {1'b0, den}) : shifted[31:0];
        quo <= {quo[30:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/interpolated_emission_sampler.sv
// load transactions: result in the cycle after acceptance, busy stays low, one per cycle
// sample: searches the rows, weights every bin in use (with a divide when two rows blend),
// then scans the bins against the draw; the shared 32-step divider sets the pace
// a sample with zero energy returns in the cycle after acceptance
// result strobe done lasts one cycle and cannot be stalled
// synchronous reset clears control and both config registers; tables stay undefined until loaded
module interpolated_emission_sampler #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_BINS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  iesamp_pkg::item_t   item,
  output logic                done,
  output iesamp_pkg::result_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import iesamp_pkg::*;
  `include "interpolated_emission_sampler_macros.svh"

  localparam int RI_W  = $clog2(MAX_ROWS);
  localparam int RC_W  = $clog2(MAX_ROWS + 1);
  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int BC_W  = $clog2(MAX_BINS + 1);
  localparam int AW    = $clog2(MAX_ROWS * MAX_BINS);
  localparam int TOT_W = 16 + BC_W;

  function automatic logic [AW-1:0] tab_addr(input logic [RI_W-1:0] r,
                                             input logic [BIN_W-1:0] b);
    tab_addr = AW'(r) * AW'(MAX_BINS) + AW'(b);
  endfunction

  logic [15:0] row_mem [MAX_ROWS];
  logic [15:0] em_mem  [MAX_ROWS * MAX_BINS];
  logic [15:0] int_mem [MAX_ROWS * MAX_BINS];
  logic [15:0] wt_mem  [MAX_BINS];

  state_t state, state_next;

  logic [6:0]       rows_cfg;
  logic [8:0]       bins_cfg;
  logic [RC_W-1:0]  nrows;
  logic [BC_W-1:0]  nbins;
  logic [RC_W-1:0]  r_cnt;
  logic [BC_W-1:0]  b_cnt;
  logic [RI_W-1:0]  up_row, low_row;
  logic             blend;
  logic [15:0]      prev_wl, d_q, span_q, u_q, weight_q;
  logic [19:0]      e_q;
  logic [31:0]      lam_q, prod_lo, prod_hi;
  logic [TOT_W-1:0] total_q, run_q, run_n;
  logic [TOT_W+15:0] thresh_q;
  logic [15:0]      rwl_q, int_up_q, int_lo_q, sw_q, ewl_q;

  logic             accept, load_ok;
  logic [RI_W-1:0]  ld_row;
  logic [BIN_W-1:0] ld_bin, bidx;
  div_req_t         div_req;
  logic             div_busy, div_done;
  logic [31:0]      div_quo;

  iesamp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign busy      = state != ST_IDLE;
  assign accept    = start && !busy;
  assign ld_row    = RI_W'(item.row_index);
  assign ld_bin    = BIN_W'(item.bin_index);
  assign bidx      = b_cnt[BIN_W-1:0];
  assign load_ok   = 32'(item.row_index) < MAX_ROWS
                     && (item.kind == KIND_EXC || 32'(item.bin_index) < MAX_BINS);
  assign nrows     = 32'(rows_cfg) > MAX_ROWS ? RC_W'(MAX_ROWS) : RC_W'(rows_cfg);
  assign nbins     = 32'(bins_cfg) > MAX_BINS ? BC_W'(MAX_BINS) : BC_W'(bins_cfg);
  assign run_n     = run_q + TOT_W'(sw_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= '0;
      bins_cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS: rows_cfg <= cfg_data[6:0];
        REG_BINS: bins_cfg <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // table stores and registered table reads
  always_ff @(posedge clk) begin
    if (accept && load_ok) begin
      case (item.kind)
        KIND_EXC: row_mem[ld_row] <= item.load_value;
        KIND_EMI: em_mem[tab_addr(ld_row, ld_bin)] <= item.load_value;
        KIND_INT: int_mem[tab_addr(ld_row, ld_bin)] <= item.load_value;
        default: ;
      endcase
    end
    if (state == ST_BIN_ACC) wt_mem[bidx] <= weight_q;
    rwl_q    <= row_mem[r_cnt[RI_W-1:0]];
    int_up_q <= int_mem[tab_addr(up_row, bidx)];
    int_lo_q <= int_mem[tab_addr(low_row, bidx)];
    sw_q     <= wt_mem[bidx];
    ewl_q    <= em_mem[tab_addr(low_row, bidx)];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    div_req.go  = 1'b0;
    div_req.num = LAMBDA_NUM;
    div_req.den = 32'(item.excitation_energy);
    case (state)
      ST_IDLE: begin
        if (accept && item.kind == KIND_SAMPLE && item.excitation_energy != '0) begin
          div_req.go = 1'b1;
          state_next = ST_LAM;
        end
      end
      ST_LAM:     if (div_done) state_next = ST_ROW_RD;
      ST_ROW_RD:  state_next = (r_cnt == nrows) ? ST_IDLE : ST_ROW_CHK;
      ST_ROW_CHK: state_next = (32'(rwl_q) > lam_q) ? ST_BIN_RD : ST_ROW_RD;
      ST_BIN_RD:  state_next = (b_cnt == nbins) ? ST_THRESH : ST_BIN_MUL;
      ST_BIN_MUL: state_next = blend ? ST_BIN_SUM : ST_BIN_ACC;
      ST_BIN_SUM: begin
        div_req.go  = 1'b1;
        div_req.num = prod_lo + prod_hi;
        div_req.den = 32'(span_q);
        state_next  = ST_BIN_DIV;
      end
      ST_BIN_DIV: if (div_done) state_next = ST_BIN_ACC;
      ST_BIN_ACC: state_next = ST_BIN_RD;
      ST_THRESH:  state_next = (total_q == '0) ? ST_IDLE : ST_SCAN_RD;
      ST_SCAN_RD: state_next = (b_cnt == nbins) ? ST_IDLE : ST_SCAN_CHK;
      ST_SCAN_CHK: state_next = ({run_n, 16'b0} > thresh_q) ? ST_EM_RD : ST_SCAN_RD;
      ST_EM_RD:   state_next = ST_EM_CHK;
      ST_EM_CHK: begin
        if (ewl_q == '0) begin
          state_next = ST_IDLE;
        end else begin
          div_req.go  = 1'b1;
          div_req.num = EMIT_NUM + 32'(ewl_q >> 1);
          div_req.den = 32'(ewl_q);
          state_next  = ST_EM_DIV;
        end
      end
      ST_EM_DIV:  if (div_done) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            e_q <= item.excitation_energy;
            u_q <= item.uniform_draw;
            if (item.kind != KIND_SAMPLE) begin
              done   <= 1'b1;
              result <= '{emitted_energy: '0, status: STAT_LOAD};
            end else if (item.excitation_energy == '0) begin
              done   <= 1'b1;
              result <= '{emitted_energy: '0, status: STAT_PASS};
            end
          end
        end
        ST_LAM: begin
          lam_q <= div_quo;
          r_cnt <= '0;
        end
        ST_ROW_RD: begin
          if (r_cnt == nrows) begin
            done   <= 1'b1;
            result <= '{emitted_energy: e_q, status: STAT_PASS};
          end
        end
        ST_ROW_CHK: begin
          if (32'(rwl_q) > lam_q) begin
            up_row  <= r_cnt[RI_W-1:0];
            blend   <= r_cnt != '0;
            low_row <= (r_cnt == '0) ? '0 : RI_W'(r_cnt - 1'b1);
            d_q     <= 16'(lam_q - 32'(prev_wl));
            span_q  <= rwl_q - prev_wl;
            b_cnt   <= '0;
            total_q <= '0;
          end else begin
            prev_wl <= rwl_q;
            r_cnt   <= r_cnt + 1'b1;
          end
        end
        ST_BIN_MUL: begin
          weight_q <= int_up_q;
          prod_lo  <= 32'(int_lo_q) * 32'(span_q - d_q);
          prod_hi  <= 32'(int_up_q) * 32'(d_q);
        end
        ST_BIN_DIV: if (div_done) weight_q <= div_quo[15:0];
        ST_BIN_ACC: begin
          total_q <= total_q + TOT_W'(weight_q);
          b_cnt   <= b_cnt + 1'b1;
        end
        ST_THRESH: begin
          thresh_q <= (TOT_W+16)'(u_q) * (TOT_W+16)'(total_q);
          b_cnt    <= '0;
          run_q    <= '0;
          if (total_q == '0) begin
            done   <= 1'b1;
            result <= '{emitted_energy: '0, status: STAT_NONE};
          end
        end
        ST_SCAN_RD: begin
          if (b_cnt == nbins) begin
            done   <= 1'b1;
            result <= '{emitted_energy: '0, status: STAT_NONE};
          end
        end
        ST_SCAN_CHK: begin
          if (!({run_n, 16'b0} > thresh_q)) begin
            run_q <= run_n;
            b_cnt <= b_cnt + 1'b1;
          end
        end
        ST_EM_CHK: begin
          if (ewl_q == '0) begin
            done   <= 1'b1;
            result <= '{emitted_energy: ENERGY_MAX, status: STAT_SAMPLED};
          end
        end
        ST_EM_DIV: begin
          if (div_done) begin
            done   <= 1'b1;
            result <= '{emitted_energy: (div_quo > 32'(ENERGY_MAX)) ? ENERGY_MAX
                                                                 : div_quo[19:0],
                        status: STAT_SAMPLED};
          end
        end
        default: ;
      endcase
    end
  end

  `IES_ASSERT_NEXT(a_load_done, clk, rst, accept && item.kind != KIND_SAMPLE, done && result.status == STAT_LOAD, "load transaction gave no load result")
  `IES_ASSERT_SAME(a_div_idle, clk, rst, div_req.go, !div_busy, "divider restarted while busy")
  `IES_ASSERT_SAME(a_scan_total, clk, rst, state == ST_SCAN_CHK, total_q != '0, "scan entered with zero total")
  `IES_ASSERT_NEXT(a_div_wait, clk, rst, state == ST_BIN_SUM, div_busy && state == ST_BIN_DIV, "blend divide not running")

endmodule

>>> tb/interpolated_emission_sampler_test.sv
module interpolated_emission_sampler_test;
  import iesamp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    done;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [1:0]  cfg_index = REG_ROWS;
  logic [15:0] cfg_data = '0;

  interpolated_emission_sampler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block's tables and registers
  logic [15:0] exc_wl [0:63];
  logic [15:0] emi_wl [0:16383];
  logic [15:0] inten [0:16383];
  logic [6:0]  rows_cfg = '0;
  logic [8:0]  bins_cfg = '0;

  result_t pending_results [$];
  int      error_count = 0;
  int      cycles = 0;
  int      row_spacing = 100;

  function automatic longint unsigned blended_weight(int up, bit blend, longint unsigned d,
                                                     longint unsigned span, int b);
    longint unsigned hi, lo;
    hi = inten[{up[5:0], b[7:0]}];
    if (!blend) return hi;
    lo = inten[{6'(up - 1), b[7:0]}];
    return (lo * (span - d) + hi * d) / span;
  endfunction

  function automatic result_t predict_emission(item_t it);
    result_t res;
    longint unsigned e, lam, d, span, total, thresh, run, wl, en;
    int nr, nb, up, lower;
    bit found, blend;
    res.emitted_energy = '0;
    res.status = STAT_LOAD;
    if (it.kind != KIND_SAMPLE) begin
      case (it.kind)
        KIND_EXC: exc_wl[it.row_index] = it.load_value;
        KIND_EMI: emi_wl[{it.row_index, it.bin_index}] = it.load_value;
        default: inten[{it.row_index, it.bin_index}] = it.load_value;
      endcase
      return res;
    end
    e = it.excitation_energy;
    res.emitted_energy = it.excitation_energy;
    res.status = STAT_PASS;
    if (e == 0) return res;
    lam = LAMBDA_NUM / e;
    nr = int'(rows_cfg) > 64 ? 64 : int'(rows_cfg);
    nb = int'(bins_cfg) > 256 ? 256 : int'(bins_cfg);
    found = 1'b0;
    up = 0;
    for (int r = 0; r < nr && !found; r++) begin
      if (exc_wl[r] > lam) begin
        up = r;
        found = 1'b1;
      end
    end
    if (!found) return res;
    blend = (up != 0);
    lower = blend ? up - 1 : 0;
    d = 0;
    span = 0;
    if (blend) begin
      d = lam - exc_wl[lower];
      span = exc_wl[up] - exc_wl[lower];
    end
    total = 0;
    for (int b = 0; b < nb; b++) total += blended_weight(up, blend, d, span, b);
    res.emitted_energy = '0;
    res.status = STAT_NONE;
    thresh = it.uniform_draw * total;
    run = 0;
    for (int b = 0; b < nb; b++) begin
      run += blended_weight(up, blend, d, span, b);
      if ((run << 16) > thresh) begin
        wl = emi_wl[{lower[5:0], b[7:0]}];
        en = ENERGY_MAX;
        if (wl != 0) begin
          en = (EMIT_NUM + wl / 2) / wl;
          if (en > ENERGY_MAX) en = ENERGY_MAX;
        end
        res.emitted_energy = en[19:0];
        res.status = STAT_SAMPLED;
        return res;
      end
    end
    return res;
  endfunction

  // result checking
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: emitted_energy %0d status %0d",
               result.emitted_energy, result.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.emitted_energy !== want.emitted_energy) begin
          $error("emitted_energy: expected %0d, actual %0d",
                 want.emitted_energy, result.emitted_energy);
          error_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // returns at the edge that accepted the transaction
  task automatic send_item(item_t it, bit use_typed, result_t typed);
    result_t predicted;
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predicted = predict_emission(it);
    pending_results = {pending_results, (use_typed ? typed : predicted)};
  endtask

  task automatic pause_sender(bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROWS) rows_cfg = value[6:0];
    else bins_cfg = value[8:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic item_t random_item();
    item_t it;
    it.kind = 2'($urandom);
    it.row_index = 6'($urandom);
    it.bin_index = 8'($urandom);
    it.load_value = 16'($urandom);
    it.excitation_energy = 20'($urandom);
    it.uniform_draw = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] emission_value();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 1300));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] intensity_value();
    return $urandom_range(0, 6) == 0 ? 16'd0 : 16'($urandom);
  endfunction

  function automatic logic [15:0] excitation_value(int r);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(4000 + r * row_spacing + $urandom_range(0, row_spacing - 1));
  endfunction

  task automatic load_entry(int k, int r, int b, bit idle_ok);
    item_t it;
    it = random_item();
    it.kind = k[1:0];
    it.row_index = r[5:0];
    it.bin_index = b[7:0];
    case (k[1:0])
      KIND_EXC: it.load_value = excitation_value(r);
      KIND_EMI: it.load_value = emission_value();
      default: it.load_value = intensity_value();
    endcase
    send_item(it, 1'b0, '0);
    pause_sender(idle_ok);
  endtask

  // one setting of the registers: full table load, then a random mix
  task automatic run_phase(int rows_w, int bins_w, int count, bit idle_ok);
    int nr, nb, top;
    item_t it;
    drain();
    write_register(REG_ROWS, 16'(rows_w));
    write_register(REG_BINS, 16'(bins_w));
    nr = rows_w > 64 ? 64 : rows_w;
    nb = bins_w > 256 ? 256 : bins_w;
    row_spacing = nr > 8 ? 90 : 600;
    for (int r = 0; r < nr; r++) begin
      load_entry(KIND_EXC, r, $urandom, idle_ok);
      for (int b = 0; b < nb; b++) begin
        load_entry(KIND_EMI, r, b, idle_ok);
        load_entry(KIND_INT, r, b, idle_ok);
      end
    end
    top = 4000 + nr * row_spacing + 1500;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 45) begin
        it = random_item();
        it.kind = KIND_SAMPLE;
        case ($urandom_range(0, 9))
          0: it.excitation_energy = '0;
          1, 2: it.excitation_energy = 20'($urandom);
          default: it.excitation_energy = 20'(LAMBDA_NUM / $urandom_range(3000, top));
        endcase
        send_item(it, 1'b0, '0);
        pause_sender(idle_ok);
      end else if ($urandom_range(0, 4) == 0 || nr == 0 || nb == 0) begin
        // anywhere in the table, possibly outside the searched region
        it = random_item();
        if (it.kind == KIND_SAMPLE) it.kind = KIND_INT;
        send_item(it, 1'b0, '0);
        pause_sender(idle_ok);
      end else begin
        load_entry($urandom_range(0, 2), $urandom_range(0, nr - 1),
                   $urandom_range(0, nb - 1), idle_ok);
      end
    end
  endtask

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  row_index;
    logic [7:0]  bin_index;
    logic [15:0] load_value;
    logic [19:0] energy_in;
    logic [15:0] draw;
    logic [19:0] energy_out;
    logic [1:0]  status;
  } directed_row_t;

  // with no rows in use every sample passes straight through
  directed_row_t directed [] = '{
    '{KIND_EXC,    6'd0,  8'd0,   16'h0000, 20'h00000, 16'h0000, 20'h00000, STAT_LOAD},
    '{KIND_EXC,    6'd63, 8'd255, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 20'h00000, STAT_LOAD},
    '{KIND_EMI,    6'd63, 8'd255, 16'hFFFF, 20'h00000, 16'h0000, 20'h00000, STAT_LOAD},
    '{KIND_EMI,    6'd0,  8'd0,   16'h0000, 20'hFFFFF, 16'hFFFF, 20'h00000, STAT_LOAD},
    '{KIND_INT,    6'd63, 8'd255, 16'hFFFF, 20'h00000, 16'h0000, 20'h00000, STAT_LOAD},
    '{KIND_INT,    6'd0,  8'd0,   16'h0000, 20'hFFFFF, 16'hFFFF, 20'h00000, STAT_LOAD},
    '{KIND_INT,    6'd21, 8'd170, 16'h5555, 20'h55555, 16'h5555, 20'h00000, STAT_LOAD},
    '{KIND_EMI,    6'd42, 8'd85,  16'hAAAA, 20'hAAAAA, 16'hAAAA, 20'h00000, STAT_LOAD},
    '{KIND_SAMPLE, 6'd0,  8'd0,   16'h0000, 20'h00000, 16'h0000, 20'h00000, STAT_PASS},
    '{KIND_SAMPLE, 6'd63, 8'd255, 16'hFFFF, 20'h00000, 16'hFFFF, 20'h00000, STAT_PASS},
    '{KIND_SAMPLE, 6'd0,  8'd0,   16'h0000, 20'h00001, 16'h0000, 20'h00001, STAT_PASS},
    '{KIND_SAMPLE, 6'd63, 8'd255, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 20'hFFFFF, STAT_PASS},
    '{KIND_SAMPLE, 6'd5,  8'd9,   16'h1234, 20'h3199E, 16'h8000, 20'h3199E, STAT_PASS},
    '{KIND_SAMPLE, 6'd0,  8'd0,   16'h0000, 20'hAAAAA, 16'h5555, 20'hAAAAA, STAT_PASS}
  };

  initial begin
    item_t it;
    result_t typed;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      it.kind = directed[i].kind;
      it.row_index = directed[i].row_index;
      it.bin_index = directed[i].bin_index;
      it.load_value = directed[i].load_value;
      it.excitation_energy = directed[i].energy_in;
      it.uniform_draw = directed[i].draw;
      typed.emitted_energy = directed[i].energy_out;
      typed.status = directed[i].status;
      send_item(it, 1'b1, typed);
    end

    run_phase(3, 4, 80, 1'b1);
    run_phase(1, 1, 30, 1'b1);
    run_phase(4, 0, 15, 1'b1);
    run_phase(100, 1, 20, 1'b1);
    run_phase(0, 300, 10, 1'b1);
    run_phase(5, 7, 100, 1'b0);

    drain();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
